// ===== rtl/core/lls_pkg.sv =====
// ----------------------------------------------------------------------------
// Least-loaded server dispatch package
// Shared widths, constants and the structures that travel between the
// dispatcher and its row of server cells.
// ----------------------------------------------------------------------------
package lls_pkg;

    localparam int MAX_SERVERS = 16;

    // Index and counter widths follow from the number of servers.
    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W = $clog2(MAX_SERVERS + 1);

    localparam int TIME_W = 32;
    localparam int SVC_W  = 16;
    localparam int CFG_W  = 5;
    localparam int SRV_W  = 4;
    localparam int WAIT_W = 32;
    localparam int SUM_W  = 48;
    localparam int JOBS_W = 32;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 120;

    // Running minimum carried along the row of cells.
    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] val;
    } lls_cand_t;

    // Broadcast from the dispatcher to every cell.
    typedef struct packed {
        logic              clr;
        logic              wr;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] val;
    } lls_upd_t;

endpackage

// ===== rtl/core/least_loaded_server_dispatch.sv =====
// Flow: an accepted item is held while the running minimum travels one cell
// per cycle along the row of server cells (scan state); the update step then
// registers the result. A new item is accepted only once the update is done.
// A pending result does not block acceptance; it only holds the update step.
// Reset (aresetn low, synchronous): finish times, wait sum and job count
// cleared, num_servers set to 1, no result pending.
// ----------------------------------------------------------------------------
// Least-loaded server dispatch
// Assigns each job to the server that becomes free earliest and reports the
// wait, the running wait sum and the job count.
// ----------------------------------------------------------------------------
module least_loaded_server_dispatch
    import lls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,   // num_servers
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,    // arrival_time[31:0], service_time[47:32]
    input  logic                s_tuser,    // batch_start
    input  logic                s_tlast,    // last_job
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // server_index[3:0], job_wait[35:4],
                                            // wait_sum[83:36], job_count[115:84], zero pad
    output logic                m_tlast     // batch_done
);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPD} state_t;

    state_t            state_reg;
    logic [IDX_W-1:0]  scan_cnt_reg;
    logic [CFG_W-1:0]  num_srv_reg;
    logic [TIME_W-1:0] arr_reg;
    logic [SVC_W-1:0]  svc_reg;
    logic              last_reg;
    logic [SUM_W-1:0]  total_reg;
    logic [JOBS_W-1:0] jobs_reg;

    logic              m_tvalid_reg;
    logic              m_tlast_reg;
    logic [SRV_W-1:0]  o_srv_reg;
    logic [WAIT_W-1:0] o_wait_reg;
    logic [SUM_W-1:0]  o_sum_reg;
    logic [JOBS_W-1:0] o_jobs_reg;

    logic [CNT_W-1:0]      count_eff;
    logic [MAX_SERVERS-1:0] active;
    lls_cand_t             chain [MAX_SERVERS+1];
    lls_cand_t             last_cand;
    lls_upd_t              upd;

    logic              s_acc;
    logic              upd_go;
    logic              late;
    logic [WAIT_W-1:0] wait_val;
    logic [TIME_W-1:0] base_val;
    logic [TIME_W:0]   fin_sum;
    logic [TIME_W-1:0] fin_new;
    logic [SUM_W:0]    tot_sum;
    logic [SUM_W-1:0]  tot_new;
    logic [JOBS_W-1:0] jobs_new;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign upd_go    = (state_reg == ST_UPD) && (!m_tvalid_reg || m_tready);

    // Zero servers behaves as one; anything above the row length as the full row.
    always_comb begin
        if (num_srv_reg == '0) begin
            count_eff = CNT_W'(1);
        end else if (int'(num_srv_reg) > MAX_SERVERS) begin
            count_eff = CNT_W'(MAX_SERVERS);
        end else begin
            count_eff = CNT_W'(num_srv_reg);
        end
    end

    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_SERVERS; i++) begin : g_cell
        assign active[i] = (CNT_W'(i) < count_eff);

        lls_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(i)),
            .active   (active[i]),
            .upd      (upd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1])
        );
    end

    assign last_cand = chain[MAX_SERVERS];

    // Update of the chosen server and the batch totals.
    always_comb begin
        late     = last_cand.val > arr_reg;
        wait_val = late ? (last_cand.val - arr_reg) : '0;
        base_val = late ? last_cand.val : arr_reg;
        fin_sum  = {1'b0, base_val} + {{(TIME_W + 1 - SVC_W){1'b0}}, svc_reg};
        fin_new  = fin_sum[TIME_W] ? '1 : fin_sum[TIME_W-1:0];
        tot_sum  = {1'b0, total_reg} + {{(SUM_W + 1 - WAIT_W){1'b0}}, wait_val};
        tot_new  = tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];
        jobs_new = (jobs_reg == '1) ? jobs_reg : (jobs_reg + JOBS_W'(1));
    end

    always_comb begin
        upd.clr = s_acc && s_tuser;
        upd.wr  = upd_go;
        upd.idx = last_cand.idx;
        upd.val = fin_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_srv_reg <= CFG_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            num_srv_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            total_reg    <= '0;
            jobs_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tready && !upd_go) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_acc) begin
                        arr_reg      <= s_tdata[TIME_W-1:0];
                        svc_reg      <= s_tdata[TIME_W+SVC_W-1:TIME_W];
                        last_reg     <= s_tlast;
                        scan_cnt_reg <= '0;
                        state_reg    <= ST_SCAN;
                        if (s_tuser) begin
                            total_reg <= '0;
                            jobs_reg  <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
                    if (scan_cnt_reg == IDX_W'(MAX_SERVERS - 1)) begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (upd_go) begin
                        total_reg    <= tot_new;
                        jobs_reg     <= jobs_new;
                        o_srv_reg    <= SRV_W'(last_cand.idx);
                        o_wait_reg   <= wait_val;
                        o_sum_reg    <= tot_new;
                        o_jobs_reg   <= jobs_new;
                        m_tlast_reg  <= last_reg;
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(M_DATA_W - SRV_W - WAIT_W - SUM_W - JOBS_W){1'b0}},
                       o_jobs_reg, o_sum_reg, o_wait_reg, o_srv_reg};

`ifndef SYNTHESIS
    // A new item always starts the minimum search at the head of the row.
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (state_reg == ST_SCAN) && (scan_cnt_reg == '0))
        else $error("scan did not start after item acceptance");

    // The minimum reaching the end of the row always comes from some cell.
    a_cand_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> last_cand.valid)
        else $error("no candidate at the end of the row");

    // The chosen server lies within the servers in use.
    a_cand_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPD) |-> (CNT_W'(last_cand.idx) < count_eff))
        else $error("chosen server outside the configured range");

    // A result still waiting is never overwritten by the update step.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> m_tvalid_reg && $stable(o_sum_reg))
        else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/lls_cell.sv =====
// ----------------------------------------------------------------------------
// Server cell
// Holds one server's finish time and passes the running minimum on to the
// next cell each cycle.
// ----------------------------------------------------------------------------
module lls_cell
    import lls_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_idx,
    input  logic             active,
    input  lls_upd_t         upd,
    input  lls_cand_t        cand_in,
    output lls_cand_t        cand_out
);

    logic [TIME_W-1:0] finish_reg;
    lls_cand_t         cand_reg;
    lls_cand_t         cand_next;

    // Strict less-than keeps the lower index on equal finish times.
    always_comb begin
        cand_next = cand_in;
        if (active && (!cand_in.valid || (finish_reg < cand_in.val))) begin
            cand_next.valid = 1'b1;
            cand_next.idx   = cell_idx;
            cand_next.val   = finish_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            finish_reg     <= '0;
            cand_reg.valid <= 1'b0;
        end else begin
            if (upd.clr) begin
                finish_reg <= '0;
            end else if (upd.wr && (upd.idx == cell_idx)) begin
                finish_reg <= upd.val;
            end
            cand_reg.valid <= cand_next.valid;
        end
        cand_reg.idx <= cand_next.idx;
        cand_reg.val <= cand_next.val;
    end

    assign cand_out = cand_reg;

endmodule
